/* rtl/jsv_pkg.sv */
// Package for the JSON string validator: byte codes, escape and UTF-8 state codes,
// and the state structs passed between the step modules and the top level.
// No dependencies.
package jsv_pkg;

   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_B       = 8'h62;
   localparam logic [7:0] CH_F       = 8'h66;
   localparam logic [7:0] CH_N       = 8'h6E;
   localparam logic [7:0] CH_R       = 8'h72;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_U       = 8'h75;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   // escape phase codes
   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_BSL  = 2'd1;
   localparam logic [1:0] ESC_SKIP = 2'd2;

   localparam logic [2:0] HEX_SKIP_LEN = 3'd4;

   // continuation byte range classes
   localparam logic [2:0] LC_ANY  = 3'd0;   // 80-BF
   localparam logic [2:0] LC_E0   = 3'd1;   // A0-BF
   localparam logic [2:0] LC_ED   = 3'd2;   // 80-9F
   localparam logic [2:0] LC_F0   = 3'd3;   // 90-BF
   localparam logic [2:0] LC_F4   = 3'd4;   // 80-8F

   typedef struct packed {
      logic [1:0] phase;
      logic [2:0] skip;
   } esc_state_type;

   typedef struct packed {
      logic [1:0] pending;
      logic [2:0] lead_class;
   } utf8_state_type;

endpackage

/* rtl/jsv_utf8_step.sv */
// UTF-8 sequence tracker: next state and fault flag for one byte.
// Depends on jsv_pkg.
module jsv_utf8_step import jsv_pkg::*; (
   input  utf8_state_type cur,
   input  logic [7:0]     data_byte,
   output utf8_state_type nxt,
   output logic           fault
);

   logic [7:0] lo;
   logic [7:0] hi;

   always_comb begin
      lo = 8'h80;
      hi = 8'hBF;
      unique case (cur.lead_class)
         LC_E0:   lo = 8'hA0;
         LC_ED:   hi = 8'h9F;
         LC_F0:   lo = 8'h90;
         LC_F4:   hi = 8'h8F;
         default: ;
      endcase
   end

   always_comb begin
      nxt   = cur;
      fault = 1'b0;
      if (cur.pending != 2'd0) begin
         nxt.lead_class = LC_ANY;
         if (data_byte < lo || data_byte > hi) begin
            fault       = 1'b1;
            nxt.pending = 2'd0;
         end else begin
            nxt.pending = cur.pending - 2'd1;
         end
      end else if (data_byte < 8'h80) begin
         nxt = cur;
      end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
         nxt.pending    = 2'd1;
         nxt.lead_class = LC_ANY;
      end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
         nxt.pending    = 2'd2;
         nxt.lead_class = (data_byte == 8'hE0) ? LC_E0 :
                          (data_byte == 8'hED) ? LC_ED : LC_ANY;
      end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
         nxt.pending    = 2'd3;
         nxt.lead_class = (data_byte == 8'hF0) ? LC_F0 :
                          (data_byte == 8'hF4) ? LC_F4 : LC_ANY;
      end else begin
         fault = 1'b1;
      end
   end

endmodule

/* rtl/jsv_content_step.sv */
// JSON string content tracker: escape handling and forbidden bytes for one byte.
// Depends on jsv_pkg.
module jsv_content_step import jsv_pkg::*; (
   input  esc_state_type cur,
   input  logic [7:0]    data_byte,
   output esc_state_type nxt,
   output logic          fault
);

   logic short_esc;
   logic [2:0] skip_dec;

   assign short_esc = (data_byte == CH_QUOTE) || (data_byte == CH_BSLASH) ||
                      (data_byte == CH_SLASH) || (data_byte == CH_B) ||
                      (data_byte == CH_F) || (data_byte == CH_N) ||
                      (data_byte == CH_R) || (data_byte == CH_T);
   assign skip_dec  = cur.skip - 3'd1;

   always_comb begin
      nxt   = cur;
      fault = 1'b0;
      unique case (cur.phase)
         ESC_BSL: begin
            if (short_esc) begin
               nxt.phase = ESC_NONE;
            end else if (data_byte == CH_U) begin
               nxt.phase = ESC_SKIP;
               nxt.skip  = HEX_SKIP_LEN;
            end else begin
               fault     = 1'b1;
               nxt.phase = ESC_NONE;
            end
         end
         ESC_SKIP: begin
            nxt.skip = skip_dec;
            if (skip_dec == 3'd0) begin
               nxt.phase = ESC_NONE;
            end
         end
         default: begin
            if (data_byte == CH_BSLASH) begin
               nxt.phase = ESC_BSL;
            end else if (data_byte < CTRL_LIMIT || data_byte == CH_QUOTE) begin
               fault = 1'b1;
            end
         end
      endcase
   end

endmodule

/* rtl/json_string_validator_unit.sv */
// A byte marked last is registered in the input stage; its verdict is then registered in the rsp stage.
// Throughput: one byte per cycle; a stalled rsp only holds back a byte marked last.
// Bytes without tlast give no rsp transfer; each tlast byte gives one verdict.
// Reset (synchronous, active high) clears quoted mode, run state and both stages.
// Top level of the JSON string validator; uses jsv_pkg, jsv_utf8_step, jsv_content_step.
module json_string_validator_unit import jsv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] string_valid, [7:1] zero
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // quoted_mode
);

   logic           quoted_ff, quoted_in;
   logic           s1_valid_ff, s1_valid_in;
   logic [7:0]     s1_byte_ff, s1_byte_in;
   logic           s1_last_ff, s1_last_in;
   logic           at_start_ff, at_start_in;
   logic           failed_ff, failed_in;
   esc_state_type  esc_ff, esc_in;
   utf8_state_type utf8_ff, utf8_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           verdict_ff, verdict_in;

   utf8_state_type utf8_nxt;
   logic           utf8_fault;
   esc_state_type  esc_nxt;
   logic           esc_fault;
   logic           s1_adv;
   logic           fail;
   esc_state_type  esc_upd;

   jsv_utf8_step u_utf8 (
      .cur       (utf8_ff),
      .data_byte (s1_byte_ff),
      .nxt       (utf8_nxt),
      .fault     (utf8_fault)
   );

   jsv_content_step u_content (
      .cur       (esc_ff),
      .data_byte (s1_byte_ff),
      .nxt       (esc_nxt),
      .fault     (esc_fault)
   );

   assign s1_adv     = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, verdict_ff};

   always_comb begin
      fail    = failed_ff | utf8_fault;
      esc_upd = esc_ff;
      if (quoted_ff) begin
         if (at_start_ff) begin
            if (s1_byte_ff != CH_QUOTE || s1_last_ff) fail = 1'b1;
         end else if (s1_last_ff) begin
            if (s1_byte_ff != CH_QUOTE || esc_ff.phase != ESC_NONE) fail = 1'b1;
         end else begin
            esc_upd = esc_nxt;
            fail    = fail | esc_fault;
         end
      end else begin
         esc_upd = esc_nxt;
         fail    = fail | esc_fault;
         if (s1_last_ff && esc_nxt.phase != ESC_NONE) fail = 1'b1;
      end
      if (s1_last_ff && utf8_nxt.pending != 2'd0) fail = 1'b1;
   end

   always_comb begin
      quoted_in    = (csr_valid && csr_ready) ? csr_data : quoted_ff;
      s1_valid_in  = s1_valid_ff;
      s1_byte_in   = s1_byte_ff;
      s1_last_in   = s1_last_ff;
      at_start_in  = at_start_ff;
      failed_in    = failed_ff;
      esc_in       = esc_ff;
      utf8_in      = utf8_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      verdict_in   = verdict_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
         if (s1_last_ff) begin
            at_start_in  = 1'b1;
            failed_in    = 1'b0;
            esc_in       = '0;
            utf8_in      = '0;
            rsp_valid_in = 1'b1;
            verdict_in   = !fail;
         end else begin
            at_start_in = 1'b0;
            failed_in   = fail;
            esc_in      = esc_upd;
            utf8_in     = utf8_nxt;
         end
      end
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quoted_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         at_start_ff  <= 1'b1;
         failed_ff    <= 1'b0;
         esc_ff       <= '0;
         utf8_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         quoted_ff    <= quoted_in;
         s1_valid_ff  <= s1_valid_in;
         at_start_ff  <= at_start_in;
         failed_ff    <= failed_in;
         esc_ff       <= esc_in;
         utf8_ff      <= utf8_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
      verdict_ff <= verdict_in;
   end

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> rsp_valid_ff)
      else $error("last byte did not load a verdict");

   a_run_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (at_start_ff && !failed_ff &&
                                  esc_ff.phase == ESC_NONE && utf8_ff.pending == 2'd0))
      else $error("run state not cleared after verdict");

   a_skip_count_live: assert property (@(posedge clock) disable iff (reset)
      (esc_ff.phase == ESC_SKIP) |-> (esc_ff.skip != 3'd0))
      else $error("hex skip phase with zero count");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_byte_ff) &&
                                    $stable(s1_last_ff)))
      else $error("stalled input stage changed");

endmodule
